// File: hdl/accel_step_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the step counter
// Wrappers that clock on clk and switch off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_STEP_COUNTER_TOP_DEFINES_SVH
`define ACCEL_STEP_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the step counter.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int ACCEL_W       = 13;
    localparam int MAG_W         = 14;
    localparam int THRESH_W      = 14;
    localparam int GAP_W         = 8;
    localparam int TODAY_W       = 24;
    localparam int DAY_W         = 16;
    localparam int REPORTED_DAYS = 7;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 144;
    localparam int CFG_DATA_W    = 14;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd340;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 8'd12;
    localparam logic [GAP_W-1:0]    GAP_MAX      = 8'd255;
    localparam logic [TODAY_W-1:0]  TODAY_MAX    = 24'hFF_FFFF;
    localparam logic [DAY_W-1:0]    DAY_CAP      = 16'hFFFF;

    typedef enum logic {
        MODE_SAMPLE   = 1'b0,
        MODE_ROLLOVER = 1'b1
    } mode_t;

    typedef enum logic {
        REG_DELTA_THRESHOLD = 1'b0,
        REG_MIN_STEP_GAP    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
        logic                      vibrating;
    } item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] delta_threshold;
        logic [GAP_W-1:0]    min_step_gap;
    } cfg_t;

    typedef struct packed {
        logic                                step_detected;
        logic [TODAY_W-1:0]                  steps_today;
        logic [REPORTED_DAYS-1:0][DAY_W-1:0] past_day;   // [0] = most recent day
    } result_t;

    // Magnitude of a 13-bit two's complement value; -4096 gives 4096.
    function automatic logic [ACCEL_W-1:0] abs_accel(input logic [ACCEL_W-1:0] v);
        logic [ACCEL_W-1:0] neg;
        neg = ~v + {{(ACCEL_W-1){1'b0}}, 1'b1};
        return v[ACCEL_W-1] ? neg : v;
    endfunction

endpackage

// File: hdl/asc_core.sv
// ----------------------------------------------------------------------------
// asc_core
// Step detector state, per-item update and result forming.
// ----------------------------------------------------------------------------
module asc_core
    import asc_pkg::*;
#(
    parameter int HISTORY_DAYS = 7
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,     // item in `item` is consumed this cycle
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [MAG_W-1:0]   last_mag_reg, last_mag_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [TODAY_W-1:0] today_reg, today_next;
    logic [DAY_W-1:0]   hist_reg  [HISTORY_DAYS];
    logic [DAY_W-1:0]   hist_next [HISTORY_DAYS];

    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   delta;
    logic [GAP_W-1:0]   gap_bump;
    logic               hit;
    logic               step;

    wire  [REPORTED_DAYS-1:0][DAY_W-1:0] past_days;

    assign mag = MAG_W'(abs_accel(item.accel_x)) + MAG_W'(abs_accel(item.accel_y))
               + MAG_W'(abs_accel(item.accel_z));
    assign delta    = (mag >= last_mag_reg) ? (mag - last_mag_reg) : (last_mag_reg - mag);
    assign gap_bump = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 8'd1;
    assign hit      = (delta > cfg.delta_threshold) && (gap_reg >= cfg.min_step_gap);

    always_comb
    begin
        last_mag_next = last_mag_reg;
        gap_next      = gap_reg;
        today_next    = today_reg;
        hist_next     = hist_reg;
        step          = 1'b0;
        case (item.mode)
            MODE_ROLLOVER:
            begin
                for (int i = HISTORY_DAYS - 1; i > 0; i--)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                hist_next[0] = (today_reg > TODAY_W'(DAY_CAP)) ? DAY_CAP
                                                              : today_reg[DAY_W-1:0];
                today_next   = '0;
            end
            default:
            begin
                if (item.vibrating)
                begin
                    gap_next = gap_bump;
                end
                else
                begin
                    if (hit)
                    begin
                        step     = 1'b1;
                        gap_next = '0;
                        if (today_reg != TODAY_MAX)
                        begin
                            today_next = today_reg + 24'd1;
                        end
                    end
                    else
                    begin
                        gap_next = gap_bump;
                    end
                    last_mag_next = mag;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mag_reg <= '0;
            gap_reg      <= GAP_RESET;
            today_reg    <= '0;
            for (int i = 0; i < HISTORY_DAYS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            last_mag_reg <= last_mag_next;
            gap_reg      <= gap_next;
            today_reg    <= today_next;
            hist_reg     <= hist_next;
        end
    end

    // Slots beyond the history depth report zero
    for (genvar k = 0; k < REPORTED_DAYS; k++)
    begin : g_day
        if (k < HISTORY_DAYS)
        begin : g_live
            assign past_days[k] = hist_next[k];
        end
        else
        begin : g_zero
            assign past_days[k] = '0;
        end
    end

    always_comb
    begin
        result.step_detected = step;
        result.steps_today   = today_next;
        result.past_day      = past_days;
    end

endmodule

// File: hdl/accel_step_counter_top.sv
// ----------------------------------------------------------------------------
// accel_step_counter_top
// Step counter on an accelerometer stream with a day history.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one item per handshake: either an accelerometer
//   sample (s_tuser = 0) or a day rollover (s_tuser = 1). Master stream (m_*)
//   returns exactly one result item per input item, in order: step flag,
//   today's count and the seven most recent finished days.
//   Configuration (threshold, minimum gap) is written through cfg_we /
//   cfg_addr / cfg_data while the block is idle; writes take effect at once.
//   Path: an accepted item moves from the input register to the result register and out on m_*.
//   Throughput: one item per cycle while m_tready stays high. The input register feeds the
//   update logic and state registers; the result register holds the output.
//   Every item depends on the state left by the one before, and that update
//   completes in the same cycle an item leaves the input register.
//   Stall: with m_tready low the result register holds and the input
//   register still takes one more item; s_tready drops only when both full.
//   Reset: rst_n low clears both stages, restores the register defaults
//   (threshold 340, gap 12), sets the gap counter to 12, today's count and
//   the history to zero. No clearing pass; items flow right after reset.
// ----------------------------------------------------------------------------
`include "accel_step_counter_top_defines.svh"

module accel_step_counter_top
    import asc_pkg::*;
#(
    parameter int HISTORY_DAYS = 7     // 1 .. 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z, vibrating
    input  logic                   s_tuser,   // mode

    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // step_detected, steps_today,
                                              // past_day_1 .. past_day_7, zero pad

    // Configuration writes
    input  logic                   cfg_we,
    input  logic                   cfg_addr,  // 0 delta_threshold, 1 min_step_gap
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RESULT_W = $bits(result_t);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;

    item_t   s_item;
    result_t core_result;
    logic    advance;
    logic    s_accept;

    // Unpack the slave side
    assign s_item.mode      = mode_t'(s_tuser);
    assign s_item.accel_x   = s_tdata[12:0];
    assign s_item.accel_y   = s_tdata[25:13];
    assign s_item.accel_z   = s_tdata[38:26];
    assign s_item.vibrating = s_tdata[39];

    // The input stage moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delta_threshold <= THRESH_RESET;
            cfg_reg.min_step_gap    <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DELTA_THRESHOLD: cfg_reg.delta_threshold <= cfg_data[THRESH_W-1:0];
                REG_MIN_STEP_GAP:    cfg_reg.min_step_gap    <= cfg_data[GAP_W-1:0];
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    asc_core #(
        .HISTORY_DAYS (HISTORY_DAYS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Pack the master side: step flag in bit 0, then the count, then days 1..7
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0),
                       out_result_reg.past_day[6], out_result_reg.past_day[5],
                       out_result_reg.past_day[4], out_result_reg.past_day[3],
                       out_result_reg.past_day[2], out_result_reg.past_day[1],
                       out_result_reg.past_day[0],
                       out_result_reg.steps_today, out_result_reg.step_detected};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASC_ASSERT_NEXT(a_accept_lands, s_accept, in_valid_reg,
        "accepted item did not reach the input register")

    `ASC_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg),
        "blocked input stage lost or changed its item")

    `ASC_ASSERT_NEXT(a_rollover_clears,
        advance && (in_item_reg.mode == MODE_ROLLOVER),
        out_valid_reg && !out_result_reg.step_detected
            && (out_result_reg.steps_today == '0),
        "rollover result did not show a cleared day count")

endmodule
